[src/v2n_pkg.sv]
`default_nettype none
package v2n_pkg;
	localparam int unsigned IN_WIDTH_DEF      = 16;
	localparam int unsigned OUT_FRAC_BITS_DEF = 14;
endpackage
`default_nettype wire

[src/v2n_in_if.sv]
`default_nettype none
interface v2n_in_if #(
	parameter int unsigned IN_WIDTH = v2n_pkg::IN_WIDTH_DEF
);
	logic                       valid;
	logic                       ready;
	logic signed [IN_WIDTH-1:0] in_x;
	logic signed [IN_WIDTH-1:0] in_y;
	modport source (output valid, in_x, in_y, input ready);
	modport sink (input valid, in_x, in_y, output ready);
endinterface
`default_nettype wire

[src/v2n_out_if.sv]
`default_nettype none
interface v2n_out_if #(
	parameter int unsigned OUT_FRAC_BITS = v2n_pkg::OUT_FRAC_BITS_DEF
);
	logic                            valid;
	logic                            ready;
	logic signed [OUT_FRAC_BITS+1:0] unit_x;
	logic signed [OUT_FRAC_BITS+1:0] unit_y;
	logic                            was_zero;
	modport source (output valid, unit_x, unit_y, was_zero, input ready);
	modport sink (input valid, unit_x, unit_y, was_zero, output ready);
endinterface
`default_nettype wire

[src/v2n_isqrt.sv]
`default_nettype none
// Pipelined floor square root: two result bits per stage.
module v2n_isqrt #(
	parameter int unsigned W = 32,
	parameter int unsigned TW = 8
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [W-1:0]  rad,
	input  wire logic [TW-1:0] tag_in,
	output logic [W/2-1:0]     root,
	output logic [TW-1:0]      tag_out
);
	import v2n_pkg::*;
	localparam int unsigned R  = W / 2;
	localparam int unsigned NS = (R + 1) / 2;

	logic [W-1:0]  rem_s [NS+1];
	logic [R-1:0]  res_s [NS+1];
	logic [W-1:0]  rad_s [NS+1];
	logic [TW-1:0] tag_s [NS+1];

	always_comb begin
		rem_s[0] = '0;
		res_s[0] = '0;
		rad_s[0] = rad;
		tag_s[0] = tag_in;
	end

	for (genvar g = 0; g < NS; g++) begin : g_stage
		logic [W-1:0]  rem_c;
		logic [R-1:0]  res_c;
		logic [W-1:0]  rad_c;
		always_comb begin
			logic [W+1:0] trial;
			logic [W+1:0] rr;
			rem_c = rem_s[g];
			res_c = res_s[g];
			rad_c = rad_s[g];
			for (int k = 0; k < 2; k++) begin
				if (g * 2 + k < R) begin
					rr    = {rem_c, rad_c[W-1 -: 2]};
					rad_c = rad_c << 2;
					trial = {res_c, 2'b01};
					if (rr >= trial) begin
						rem_c = W'(rr - trial);
						res_c = {res_c[R-2:0], 1'b1};
					end else begin
						rem_c = W'(rr);
						res_c = {res_c[R-2:0], 1'b0};
					end
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1] <= rem_c;
				res_s[g+1] <= res_c;
				rad_s[g+1] <= rad_c;
				tag_s[g+1] <= tag_s[g];
			end
		end
	end

	assign root    = res_s[NS];
	assign tag_out = tag_s[NS];
endmodule
`default_nettype wire

[src/v2n_div.sv]
`default_nettype none
// Pipelined restoring divider, two quotient bits per stage; num < 2^QW * den.
module v2n_div #(
	parameter int unsigned NW = 32,
	parameter int unsigned DW = 16,
	parameter int unsigned QW = 16
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic [QW-1:0]      quo
);
	import v2n_pkg::*;
	localparam int unsigned NS = (QW + 1) / 2;
	localparam int unsigned RW = DW + 1;

	logic [RW-1:0] rem_s [NS+1];
	logic [NW-1:0] num_s [NS+1];
	logic [DW-1:0] den_s [NS+1];
	logic [QW-1:0] quo_s [NS+1];

	always_comb begin
		num_s[0] = num;
		den_s[0] = den;
		quo_s[0] = '0;
		rem_s[0] = RW'(num >> QW);
	end

	for (genvar g = 0; g < NS; g++) begin : g_stage
		logic [RW-1:0] rem_c;
		logic [QW-1:0] quo_c;
		always_comb begin
			logic [RW:0] t;
			rem_c = rem_s[g];
			quo_c = quo_s[g];
			for (int k = 0; k < 2; k++) begin
				if (g * 2 + k < QW) begin
					t = {rem_c, num_s[g][QW-1-(g*2+k)]};
					if (t >= (RW+1)'(den_s[g])) begin
						rem_c = RW'(t - (RW+1)'(den_s[g]));
						quo_c = {quo_c[QW-2:0], 1'b1};
					end else begin
						rem_c = RW'(t);
						quo_c = {quo_c[QW-2:0], 1'b0};
					end
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1] <= rem_c;
				quo_s[g+1] <= quo_c;
				num_s[g+1] <= num_s[g];
				den_s[g+1] <= den_s[g];
			end
		end
	end

	assign quo = quo_s[NS];
endmodule
`default_nettype wire

[src/vector2d_safe_normalize.sv]
`default_nettype none
// Safe 2D vector normalization.
// in:  request carries in_x, in_y (signed, IN_WIDTH bits).
// out: request carries unit_x, unit_y (signed Q1.OUT_FRAC_BITS) and was_zero.
// Both channels use valid/ready; a request moves when both are high.
// One request is accepted every cycle while the output side takes results.
// Register stages: 1 (squares) + ceil((IN_WIDTH+1)/2) square root stages
// + 1 (numerator) + ceil((OUT_FRAC_BITS+2)/2) divider stages
// + 1 (round/saturate); 20 stages at the defaults. The depth is set by the
// root and divider pipelines, two bits per stage.
// The whole pipeline advances together; when the receiver holds ready low
// with a result waiting, every stage holds and in.ready drops, so nothing
// is lost or repeated. While the output register is empty the pipe keeps
// moving, but gaps inside the pipe are not closed up during a stall.
// Reset clears all valid bits; results in flight are dropped.
module vector2d_safe_normalize #(
	parameter int unsigned IN_WIDTH      = v2n_pkg::IN_WIDTH_DEF,
	parameter int unsigned OUT_FRAC_BITS = v2n_pkg::OUT_FRAC_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	v2n_in_if.sink    in,
	v2n_out_if.source out
);
	import v2n_pkg::*;
	localparam int unsigned MW  = IN_WIDTH;          // magnitude width
	localparam int unsigned SW  = 2 * MW + 1;        // sum of squares
	localparam int unsigned SWE = SW + (SW % 2);
	localparam int unsigned LW  = SWE / 2;           // root width
	localparam int unsigned QW  = OUT_FRAC_BITS + 2; // quotient width
	localparam int unsigned NW  = MW + OUT_FRAC_BITS + 1;
	localparam int unsigned TW  = 2 * MW + 3;        // mx, my, nx, ny, zero
	localparam int unsigned RS  = (LW + 1) / 2;
	localparam int unsigned DS  = (QW + 1) / 2;
	localparam int unsigned NV  = 1 + RS + 1 + DS + 1;

	logic [NV-1:0] vld_q;
	logic          en;
	assign en       = !vld_q[NV-1] || out.ready;
	assign in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NV-2:0], in.valid};
		end
	end

	// stage 1: magnitudes and squares
	logic [MW-1:0] mx_c, my_c;
	assign mx_c = in.in_x[MW-1] ? MW'(-in.in_x) : MW'(in.in_x);
	assign my_c = in.in_y[MW-1] ? MW'(-in.in_y) : MW'(in.in_y);

	logic [SWE-1:0] sq_s1;
	logic [TW-1:0]  tag_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1  <= SWE'(mx_c) * SWE'(mx_c) + SWE'(my_c) * SWE'(my_c);
			tag_s1 <= {mx_c, my_c, in.in_x[MW-1], in.in_y[MW-1],
				(mx_c == '0) && (my_c == '0)};
		end
	end

	logic [LW-1:0] len_c;
	logic [TW-1:0] tag_c;
	v2n_isqrt #(.W(SWE), .TW(TW)) u_sqrt (
		.clk, .en, .rad(sq_s1), .tag_in(tag_s1),
		.root(len_c), .tag_out(tag_c)
	);

	// numerators with half-divisor rounding term
	logic [NW-1:0] numx_s2, numy_s2;
	logic [MW-1:0] lenx_s2;
	logic [2:0]    flg_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			numx_s2 <= (NW'(tag_c[TW-1 -: MW]) << OUT_FRAC_BITS) + NW'(len_c >> 1);
			numy_s2 <= (NW'(tag_c[TW-1-MW -: MW]) << OUT_FRAC_BITS)
				+ NW'(len_c >> 1);
			lenx_s2 <= (len_c == '0) ? MW'(1) : MW'(len_c);
			flg_s2  <= tag_c[2:0];
		end
	end

	logic [QW-1:0] qx_c, qy_c;
	v2n_div #(.NW(NW), .DW(MW), .QW(QW)) u_divx (
		.clk, .en, .num(numx_s2), .den(lenx_s2), .quo(qx_c)
	);
	v2n_div #(.NW(NW), .DW(MW), .QW(QW)) u_divy (
		.clk, .en, .num(numy_s2), .den(lenx_s2), .quo(qy_c)
	);

	logic [2:0] flg_d [DS+1];
	assign flg_d[0] = flg_s2;
	for (genvar g = 0; g < DS; g++) begin : g_flg
		always_ff @(posedge clk) begin
			if (en) flg_d[g+1] <= flg_d[g];
		end
	end

	localparam logic [QW-1:0] ONE = QW'(1) << OUT_FRAC_BITS;
	logic [QW-1:0] sx_c, sy_c;
	assign sx_c = (qx_c > ONE) ? ONE : qx_c;
	assign sy_c = (qy_c > ONE) ? ONE : qy_c;

	logic signed [QW-1:0] ux_s3, uy_s3;
	logic                 z_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			z_s3 <= flg_d[DS][0];
			if (flg_d[DS][0]) begin
				ux_s3 <= ONE;
				uy_s3 <= '0;
			end else begin
				ux_s3 <= flg_d[DS][2] ? -sx_c : sx_c;
				uy_s3 <= flg_d[DS][1] ? -sy_c : sy_c;
			end
		end
	end

	assign out.valid    = vld_q[NV-1];
	assign out.unit_x   = ux_s3;
	assign out.unit_y   = uy_s3;
	assign out.was_zero = z_s3;
endmodule
`default_nettype wire

[bench/v2n_check.sv]
`timescale 1ns / 100ps
module v2n_check (
	input  wire logic clk,
	input  wire logic arst_n,
	v2n_in_if.sink    in_mon,
	v2n_out_if.sink   out_mon,
	output int        fail_count,
	output int        pending
);
	import v2n_pkg::*;
	localparam int unsigned IW = IN_WIDTH_DEF;
	localparam int unsigned FB = OUT_FRAC_BITS_DEF;

	typedef struct packed {
		logic signed [FB+1:0] ux;
		logic signed [FB+1:0] uy;
		logic                 zero;
	} unit_vec_t;

	unit_vec_t unit_q[$];

	function automatic logic [63:0] isqrt(input logic [63:0] n);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic logic signed [FB+1:0] scale(input logic [63:0] m, input logic neg,
			input logic [63:0] len);
		logic [63:0] q;
		q = ((m << FB) + (len >> 1)) / len;
		if (q > (64'd1 << FB)) q = 64'd1 << FB;
		if (neg) q = -q;
		return q[FB+1:0];
	endfunction

	function automatic unit_vec_t normalize(input logic signed [IW-1:0] x,
			input logic signed [IW-1:0] y);
		unit_vec_t r;
		logic [63:0] mx, my;
		mx = x[IW-1] ? 64'(-65'(x)) : 64'(x);
		my = y[IW-1] ? 64'(-65'(y)) : 64'(y);
		if (mx == 0 && my == 0) begin
			r.ux = (FB+2)'(1) << FB;
			r.uy = 0;
			r.zero = 1'b1;
		end else begin
			r.ux = scale(mx, x[IW-1], isqrt(mx * mx + my * my));
			r.uy = scale(my, y[IW-1], isqrt(mx * mx + my * my));
			r.zero = 1'b0;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		unit_vec_t e;
		if (!arst_n) begin
			fail_count <= 0;
			pending <= 0;
			unit_q.delete();
		end else begin
			if (out_mon.valid && out_mon.ready) begin
				if (unit_q.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected result %0d %0d %0b", out_mon.unit_x,
							out_mon.unit_y, out_mon.was_zero);
				end else begin
					e = unit_q.pop_front();
					if (e.ux !== out_mon.unit_x || e.uy !== out_mon.unit_y ||
							e.zero !== out_mon.was_zero) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("mismatch: exp %0d %0d %0b got %0d %0d %0b",
								e.ux, e.uy, e.zero, out_mon.unit_x, out_mon.unit_y,
								out_mon.was_zero);
					end
				end
			end
			if (in_mon.valid && in_mon.ready)
				unit_q.push_back(normalize(in_mon.in_x, in_mon.in_y));
			pending <= unit_q.size();
		end
	end
endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
module tb;
	import v2n_pkg::*;
	localparam int unsigned IW = IN_WIDTH_DEF;
	localparam int LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending;
	int   quiet;
	bit   timed_out = 1'b0;

	v2n_in_if  #(.IN_WIDTH(IW)) in_ch ();
	v2n_out_if #(.OUT_FRAC_BITS(OUT_FRAC_BITS_DEF)) out_ch ();

	vector2d_safe_normalize dut (.clk(clk), .arst_n(arst_n), .in(in_ch), .out(out_ch));
	v2n_check chk (.clk(clk), .arst_n(arst_n), .in_mon(in_ch), .out_mon(out_ch),
		.fail_count(fail_count), .pending(pending));

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.in_x = '0;
		in_ch.in_y = '0;
		out_ch.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 9) < 6) return 0;
		if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver stalls; some stretches run with ready held high
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			out_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			g = ($urandom_range(0, 3) == 0) ? 0 : gap_len();
			if (g > 0) begin
				out_ch.ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send(input logic signed [IW-1:0] x, input logic signed [IW-1:0] y);
		in_ch.valid <= 1'b1;
		in_ch.in_x <= x;
		in_ch.in_y <= y;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	function automatic logic signed [IW-1:0] rand_comp();
		case ($urandom_range(0, 4))
			0: return IW'($urandom_range(0, 7)) - IW'(3);
			1: return $urandom_range(0, 1) ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
			default: return IW'($urandom);
		endcase
	endfunction

	initial begin
		logic signed [IW-1:0] mn, mx;
		int g;
		mn = {1'b1, {(IW-1){1'b0}}};
		mx = {1'b0, {(IW-1){1'b1}}};
		@(posedge arst_n);
		@(posedge clk);
		send(0, 0);
		send(mn, mn);
		send(mn, 0);
		send(0, mn);
		send(mx, mx);
		send(mx, mn);
		send(mn, mx);
		send(1, 0);
		send(0, -1);
		send(-1, -1);
		send(1, 1);
		send(3, 4);
		send(-3, 4);
		send(1, 2);
		send(-1, 2);
		send(mx, 1);
		send(1, mn);
		send(-1, 0);
		send(2, 2);
		send(16'sh5555, -16'sh2aab);
		for (int i = 0; i < 600; i++) begin
			g = gap_len();
			if (g > 0) begin
				in_ch.valid <= 1'b0;
				repeat (g) @(posedge clk);
			end
			send(rand_comp(), rand_comp());
		end
		in_ch.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
